FILE: src/cpi_pkg.sv
package cpi_pkg;

  // Fixed field widths
  localparam int SAMPLE_W   = 12;
  localparam int ERR_W      = SAMPLE_W + 1;
  localparam int GAIN_W     = 20;
  localparam int DIV_W      = 5;
  localparam int TICK_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 2;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE = {SAMPLE_W{1'b1}};
  localparam logic [DIV_W-1:0]    DIV_MAX    = 5'd16;

  // Register reset values
  localparam logic                     SPEED_MODE_RST      = 1'b1;
  localparam logic [DIV_W-1:0]         OUTER_DIVIDE_RST    = 5'd2;
  localparam logic signed [GAIN_W-1:0] INNER_GAIN_NOW_RST  = 20'sd136936;
  localparam logic signed [GAIN_W-1:0] INNER_GAIN_PREV_RST = -20'sd123896;
  localparam logic signed [GAIN_W-1:0] OUTER_GAIN_NOW_RST  = 20'sd292966;
  localparam logic signed [GAIN_W-1:0] OUTER_GAIN_PREV_RST = -20'sd285699;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_MODE      = 3'd0,
    CFG_OUTER_DIVIDE    = 3'd1,
    CFG_INNER_GAIN_NOW  = 3'd2,
    CFG_INNER_GAIN_PREV = 3'd3,
    CFG_OUTER_GAIN_NOW  = 3'd4,
    CFG_OUTER_GAIN_PREV = 3'd5
  } cfg_idx_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // latch input beat, step decimation count
    logic mul_en;     // load product register
    logic outer_sel;  // 1: speed loop operands, 0: current loop operands
    logic prev_sel;   // 1: previous-error term, 0: present-error term
    logic acc_start;  // sum <= accumulator + product
    logic fin_outer;  // clamp and write speed loop accumulator
    logic fin_inner;  // clamp and write duty accumulator, load result
  } cpi_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic upd_now;    // speed loop is due on the beat being offered
  } cpi_stat_t;

endpackage

FILE: src/cpi_ctrl.sv
module cpi_ctrl
  import cpi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  cpi_stat_t stat,
  output cpi_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_OMUL0 = 7'b0000010,
    S_OMUL1 = 7'b0000100,
    S_OFIN  = 7'b0001000,
    S_IMUL0 = 7'b0010000,
    S_IMUL1 = 7'b0100000,
    S_IFIN  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Sequencer: each loop is two multiplies then an add-and-clamp
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = stat.upd_now ? S_OMUL0 : S_IMUL0;
        end
      end
      S_OMUL0: begin
        cmd.mul_en    = 1'b1;
        cmd.outer_sel = 1'b1;
        state_nxt     = S_OMUL1;
      end
      S_OMUL1: begin
        cmd.mul_en    = 1'b1;
        cmd.outer_sel = 1'b1;
        cmd.prev_sel  = 1'b1;
        cmd.acc_start = 1'b1;
        state_nxt     = S_OFIN;
      end
      S_OFIN: begin
        cmd.outer_sel = 1'b1;
        cmd.fin_outer = 1'b1;
        state_nxt     = S_IMUL0;
      end
      S_IMUL0: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_IMUL1;
      end
      S_IMUL1: begin
        cmd.mul_en    = 1'b1;
        cmd.prev_sel  = 1'b1;
        cmd.acc_start = 1'b1;
        state_nxt     = S_IFIN;
      end
      S_IFIN: begin
        // hold until the result register can take the new beat
        if (slot_free) begin
          cmd.fin_inner = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: src/cpi_datapath.sv
module cpi_datapath
  import cpi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  cpi_cmd_t              cmd,
  output cpi_stat_t             stat,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic [OUT_USER_W-1:0] out_user
);

  localparam int ACC_W   = SAMPLE_W + FRAC_BITS;
  localparam int PROD_W  = GAIN_W + ERR_W;
  localparam int BASE_W  = (PROD_W > ACC_W + 1) ? PROD_W : ACC_W + 1;
  localparam int SUM_W   = BASE_W + 2;
  localparam logic [SUM_W-1:0] ACC_MAX = SUM_W'(FULL_SCALE) << FRAC_BITS;

  // Configuration registers
  logic                     speed_mode_r;
  logic [DIV_W-1:0]         outer_divide_r;
  logic signed [GAIN_W-1:0] inner_gain_now_r, inner_gain_prev_r;
  logic signed [GAIN_W-1:0] outer_gain_now_r, outer_gain_prev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_mode_r      <= SPEED_MODE_RST;
      outer_divide_r    <= OUTER_DIVIDE_RST;
      inner_gain_now_r  <= INNER_GAIN_NOW_RST;
      inner_gain_prev_r <= INNER_GAIN_PREV_RST;
      outer_gain_now_r  <= OUTER_GAIN_NOW_RST;
      outer_gain_prev_r <= OUTER_GAIN_PREV_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPEED_MODE:      speed_mode_r      <= cfg_wdata[0];
        CFG_OUTER_DIVIDE:    outer_divide_r    <= cfg_wdata[DIV_W-1:0];
        CFG_INNER_GAIN_NOW:  inner_gain_now_r  <= cfg_wdata;
        CFG_INNER_GAIN_PREV: inner_gain_prev_r <= cfg_wdata;
        CFG_OUTER_GAIN_NOW:  outer_gain_now_r  <= cfg_wdata;
        CFG_OUTER_GAIN_PREV: outer_gain_prev_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Latched samples
  logic [SAMPLE_W-1:0] cur_r, spd_r, set_r;
  logic                upd_r;

  // Loop state
  logic [TICK_W-1:0]       tick_r;
  logic [ACC_W-1:0]        tacc_r, dacc_r;
  logic signed [ERR_W-1:0] serr_prev_r, ierr_prev_r;

  // Shared multiplier and adder registers
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  sum_r;

  // Result register
  logic [SAMPLE_W-1:0] duty_r, target_out_r;
  logic                upd_out_r, clamp_out_r;

  // Decimation limit, out-of-range dividers pinned to 1..16
  logic [TICK_W-1:0] div_m1;
  always_comb begin
    if (outer_divide_r == '0) begin
      div_m1 = '0;
    end else if (outer_divide_r > DIV_MAX) begin
      div_m1 = TICK_W'(DIV_MAX - 5'd1);
    end else begin
      div_m1 = TICK_W'(outer_divide_r - 5'd1);
    end
  end

  assign stat.upd_now = speed_mode_r && (tick_r >= div_m1);

  // Errors
  logic [SAMPLE_W-1:0]     target;
  logic signed [ERR_W-1:0] serr, ierr;

  assign target = speed_mode_r ? tacc_r[ACC_W-1:FRAC_BITS] : set_r;
  assign serr   = $signed({1'b0, set_r}) - $signed({1'b0, spd_r});
  assign ierr   = $signed({1'b0, target}) - $signed({1'b0, cur_r});

  // Multiplier operand select
  logic signed [GAIN_W-1:0] mul_g;
  logic signed [ERR_W-1:0]  mul_e;
  logic signed [PROD_W-1:0] mul_res;

  always_comb begin
    case ({cmd.outer_sel, cmd.prev_sel})
      2'b11:   begin mul_g = outer_gain_prev_r; mul_e = serr_prev_r; end
      2'b10:   begin mul_g = outer_gain_now_r;  mul_e = serr;        end
      2'b01:   begin mul_g = inner_gain_prev_r; mul_e = ierr_prev_r; end
      default: begin mul_g = inner_gain_now_r;  mul_e = ierr;        end
    endcase
  end

  assign mul_res = mul_g * mul_e;

  // Accumulate and clamp to 0 .. full scale
  logic signed [SUM_W-1:0] acc_ext, prod_ext, total;
  logic [ACC_W-1:0]        clamped;
  logic                    at_bound;

  assign acc_ext  = $signed({{(SUM_W-ACC_W){1'b0}}, (cmd.outer_sel ? tacc_r : dacc_r)});
  assign prod_ext = $signed({{(SUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r});
  assign total    = sum_r + prod_ext;

  always_comb begin
    if (total[SUM_W-1]) begin
      clamped = '0;
    end else if (total > $signed(ACC_MAX)) begin
      clamped = ACC_MAX[ACC_W-1:0];
    end else begin
      clamped = total[ACC_W-1:0];
    end
  end

  assign at_bound = (clamped == '0) || (clamped == ACC_MAX[ACC_W-1:0]);

  // Loop state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      tacc_r      <= '0;
      dacc_r      <= '0;
      serr_prev_r <= '0;
      ierr_prev_r <= '0;
    end else begin
      if (cmd.load && speed_mode_r) begin
        tick_r <= stat.upd_now ? '0 : tick_r + 1'b1;
      end
      if (cmd.fin_outer) begin
        tacc_r      <= clamped;
        serr_prev_r <= serr;
      end
      if (cmd.fin_inner) begin
        dacc_r      <= clamped;
        ierr_prev_r <= ierr;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r <= in_data[SAMPLE_W-1:0];
      spd_r <= in_data[2*SAMPLE_W-1:SAMPLE_W];
      set_r <= in_data[3*SAMPLE_W-1:2*SAMPLE_W];
      upd_r <= stat.upd_now;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_res;
    end
    if (cmd.acc_start) begin
      sum_r <= acc_ext + prod_ext;
    end
    if (cmd.fin_inner) begin
      duty_r       <= clamped[ACC_W-1:FRAC_BITS];
      target_out_r <= target;
      upd_out_r    <= upd_r;
      clamp_out_r  <= at_bound;
    end
  end

  assign out_data = {target_out_r, duty_r};
  assign out_user = {clamp_out_r, upd_out_r};

endmodule

FILE: src/cascaded_pi_speed_current_loop_unit.sv
// Each beat taken in IDLE runs IMUL0, IMUL1 and IFIN, after OMUL0, OMUL1 and OFIN
// when the speed loop updates; no new beat is taken until IFIN ends. One shared 20x13
// multiplier does the two products of each loop in turn, then an add-and-clamp.
// A finished result waits in the output register while the next beat is taken.
// Reset (rst_n low, synchronous): registers to their defaults, loop state cleared.
module cascaded_pi_speed_current_loop_unit
  import cpi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [11:0] current_sample, [23:12] speed_sample, [35:24] setpoint_sample
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [11:0] duty, [23:12] current_target
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] outer_updated, [1] duty_clamped
  output logic [OUT_USER_W-1:0] out_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cpi_cmd_t  cmd;
  cpi_stat_t stat;
  logic      in_fire;

  assign in_fire = in_tvalid && in_tready;

  cpi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cpi_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_tdata),
    .out_user  (out_tuser)
  );

`ifndef SYNTHESIS
  // one beat in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while previous beat still in work");

  // clamp flag only with duty at an end of the range
  a_clamp_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |->
      (out_tdata[SAMPLE_W-1:0] == '0) || (out_tdata[SAMPLE_W-1:0] == FULL_SCALE))
    else $error("duty_clamped set with duty inside range");

  // a new result only appears out of the final clamp step
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result raised while sequencer idle");
`endif

endmodule

FILE: tb/sv/testbench.sv
module testbench;
  import cpi_pkg::*;

  localparam int FRAC = 16;
  localparam longint ACC_TOP = longint'(FULL_SCALE) << FRAC;
  localparam int PAD_W = IN_DATA_W - 3 * SAMPLE_W;
  localparam int SETTLE_CYCLES = 10;
  localparam int QUIET_LIMIT = 4000;
  localparam int SEG_ITEMS = 178;
  localparam int MAX_PRINTED = 30;

  // One expected result beat
  typedef struct packed {
    logic [SAMPLE_W-1:0] duty;
    logic [SAMPLE_W-1:0] target;
    logic                updated;
    logic                clamped;
  } tick_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Controller copy: configuration
  bit                 ctl_speed_mode;
  bit [DIV_W-1:0]     ctl_divide;
  int                 ctl_in_now;
  int                 ctl_in_prev;
  int                 ctl_out_now;
  int                 ctl_out_prev;
  // Controller copy: loop state
  bit [TICK_W-1:0]    tick_cnt;
  longint             target_acc;
  longint             duty_acc;
  int                 speed_err_prev;
  int                 cur_err_prev;
  logic [SAMPLE_W-1:0] last_duty;

  tick_result_t expected_ticks[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int n_errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_writes = 0;
  int n_updates = 0;
  int n_clamped = 0;

  cascaded_pi_speed_current_loop_unit #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void reset_controller();
    ctl_speed_mode = SPEED_MODE_RST;
    ctl_divide     = OUTER_DIVIDE_RST;
    ctl_in_now     = INNER_GAIN_NOW_RST;
    ctl_in_prev    = INNER_GAIN_PREV_RST;
    ctl_out_now    = OUTER_GAIN_NOW_RST;
    ctl_out_prev   = OUTER_GAIN_PREV_RST;
    tick_cnt       = '0;
    target_acc     = 0;
    duty_acc       = 0;
    speed_err_prev = 0;
    cur_err_prev   = 0;
    last_duty      = '0;
  endfunction

  // Incremental PI: acc += g_now*e_now + g_prev*e_prev, clamped to 0..full scale
  function automatic longint pi_accumulate(longint acc, int g_now, int g_prev,
                                           int e_now, int e_prev, output bit at_rail);
    longint n;
    n = acc + longint'(g_now) * e_now + longint'(g_prev) * e_prev;
    if (n < 0)
      n = 0;
    else if (n > ACC_TOP)
      n = ACC_TOP;
    at_rail = (n == 0) || (n == ACC_TOP);
    return n;
  endfunction

  // One sample tick of the cascaded controller
  function automatic tick_result_t predict_tick(logic [SAMPLE_W-1:0] cur_s,
                                               logic [SAMPLE_W-1:0] spd_s,
                                               logic [SAMPLE_W-1:0] sp_s);
    tick_result_t r;
    int limit;
    int target;
    int err;
    int serr;
    bit rail;
    bit outer_rail;
    r.updated = 1'b0;
    if (ctl_speed_mode) begin
      limit = ctl_divide;
      if (limit < 1)
        limit = 1;
      if (limit > 16)
        limit = 16;
      if (int'(tick_cnt) >= limit - 1) begin
        serr = int'(sp_s) - int'(spd_s);
        tick_cnt = '0;
        target_acc = pi_accumulate(target_acc, ctl_out_now, ctl_out_prev, serr,
                                   speed_err_prev, outer_rail);
        speed_err_prev = serr;
        r.updated = 1'b1;
      end else begin
        tick_cnt = tick_cnt + 1'b1;
      end
      // integer part only
      target = int'(target_acc >>> FRAC);
    end else begin
      target = int'(sp_s);
    end
    err = target - int'(cur_s);
    duty_acc = pi_accumulate(duty_acc, ctl_in_now, ctl_in_prev, err, cur_err_prev, rail);
    cur_err_prev = err;
    r.duty = SAMPLE_W'(duty_acc >>> FRAC);
    r.target = SAMPLE_W'(target);
    r.clamped = rail;
    last_duty = r.duty;
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] sat12(int v);
    if (v < 0)
      return '0;
    if (v > int'(FULL_SCALE))
      return FULL_SCALE;
    return SAMPLE_W'(v);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rail_sample();
    return ($urandom_range(0, 1) != 0) ? FULL_SCALE : '0;
  endfunction

  // tame gains sit near the working range, otherwise any 20-bit pattern
  function automatic int pick_gain(bit tame);
    if (tame)
      return int'($urandom_range(0, 524288)) - 262144;
    return int'($signed(20'($urandom)));
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    if (n_errors <= MAX_PRINTED)
      $display("mismatch: %s at result %0d: got %0d, expected %0d", what, n_results, got, want);
  endtask

  // Send one sample beat; the model steps when the beat is taken
  task automatic send_sample(logic [SAMPLE_W-1:0] cur_s, logic [SAMPLE_W-1:0] spd_s,
                             logic [SAMPLE_W-1:0] sp_s);
    tick_result_t want;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {PAD_W'($urandom), sp_s, spd_s, cur_s};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    want = predict_tick(cur_s, spd_s, sp_s);
    expected_ticks.push_back(want);
    n_items++;
  endtask

  // Drop valid, let every pending result come out, then let the datapath settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_ticks.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_SPEED_MODE:      ctl_speed_mode = val[0];
      CFG_OUTER_DIVIDE:    ctl_divide = val[DIV_W-1:0];
      CFG_INNER_GAIN_NOW:  ctl_in_now = $signed(val);
      CFG_INNER_GAIN_PREV: ctl_in_prev = $signed(val);
      CFG_OUTER_GAIN_NOW:  ctl_out_now = $signed(val);
      CFG_OUTER_GAIN_PREV: ctl_out_prev = $signed(val);
      default: ;
    endcase
    n_writes++;
    @(posedge clk);
  endtask

  // Write all six registers on an idle block; unused upper bits get noise
  task automatic apply_config(bit mode, logic [DIV_W-1:0] div, int in_now, int in_prev,
                              int out_now, int out_prev);
    logic [CFG_DATA_W-1:0] v;
    wait_idle();
    v = CFG_DATA_W'($urandom);
    v[0] = mode;
    set_reg(CFG_SPEED_MODE, v);
    v = CFG_DATA_W'($urandom);
    v[DIV_W-1:0] = div;
    set_reg(CFG_OUTER_DIVIDE, v);
    set_reg(CFG_INNER_GAIN_NOW, CFG_DATA_W'(in_now));
    set_reg(CFG_INNER_GAIN_PREV, CFG_DATA_W'(in_prev));
    set_reg(CFG_OUTER_GAIN_NOW, CFG_DATA_W'(out_now));
    set_reg(CFG_OUTER_GAIN_PREV, CFG_DATA_W'(out_prev));
    cfg_we <= 1'b0;
  endtask

  // Reset register values, rail samples, target ramp up and back down
  task automatic test_reset_defaults();
    send_sample(12'd0, 12'd0, 12'd0);
    send_sample(FULL_SCALE, FULL_SCALE, FULL_SCALE);
    repeat (3) send_sample(12'd0, 12'd0, FULL_SCALE);
    send_sample(FULL_SCALE, 12'd0, FULL_SCALE);
    repeat (2) send_sample(12'd0, FULL_SCALE, 12'd0);
  endtask

  // Torque mode: setpoint drives the current loop, extreme gains hit both rails
  task automatic test_torque_mode();
    apply_config(1'b0, 5'd2, 524287, -524288, OUTER_GAIN_NOW_RST, OUTER_GAIN_PREV_RST);
    send_sample(12'd0, FULL_SCALE, FULL_SCALE);
    send_sample(FULL_SCALE, 12'd0, 12'd0);
    send_sample(12'd2048, 12'd100, 12'd2048);
    send_sample(12'd0, 12'd0, FULL_SCALE);
    apply_config(1'b0, 5'd2, -524288, 524287, 524287, -524288);
    send_sample(FULL_SCALE, 12'd0, 12'd0);
    send_sample(12'd0, FULL_SCALE, FULL_SCALE);
  endtask

  // Divider of zero, above range, and a count already past a lowered limit
  task automatic test_divider_limits();
    apply_config(1'b1, 5'd0, INNER_GAIN_NOW_RST, INNER_GAIN_PREV_RST,
                 OUTER_GAIN_NOW_RST, OUTER_GAIN_PREV_RST);
    send_sample(12'd100, 12'd0, FULL_SCALE);
    send_sample(12'd200, 12'd10, FULL_SCALE);
    apply_config(1'b1, 5'd16, INNER_GAIN_NOW_RST, INNER_GAIN_PREV_RST,
                 OUTER_GAIN_NOW_RST, OUTER_GAIN_PREV_RST);
    repeat (3) send_sample(12'd300, 12'd500, 12'd3000);
    apply_config(1'b1, 5'd2, INNER_GAIN_NOW_RST, INNER_GAIN_PREV_RST,
                 OUTER_GAIN_NOW_RST, OUTER_GAIN_PREV_RST);
    repeat (2) send_sample(12'd400, 12'd800, 12'd2500);
    apply_config(1'b1, 5'd31, INNER_GAIN_NOW_RST, INNER_GAIN_PREV_RST,
                 OUTER_GAIN_NOW_RST, OUTER_GAIN_PREV_RST);
    repeat (2) send_sample(12'd500, 12'd900, 12'd100);
  endtask

  // Random segments: mostly a closed loop where current follows duty and speed
  // drifts slowly, the rest noise and rail samples
  task automatic test_closed_loop();
    logic [SAMPLE_W-1:0] spd_walk;
    logic [SAMPLE_W-1:0] sp_hold;
    int pick;
    spd_walk = 12'd1000;
    sp_hold = 12'd2000;
    for (int seg = 0; seg < 8; seg++) begin
      case (seg)
        0: apply_config(1'b1, OUTER_DIVIDE_RST, INNER_GAIN_NOW_RST, INNER_GAIN_PREV_RST,
                        OUTER_GAIN_NOW_RST, OUTER_GAIN_PREV_RST);
        1: apply_config(1'b1, 5'd1, 524287, -524288, 524287, -524288);
        2: apply_config(1'b0, 5'd5, pick_gain(1'b1), pick_gain(1'b1), pick_gain(1'b1),
                        pick_gain(1'b1));
        3: apply_config(1'b1, 5'd16, -524288, 524287, -524288, 524287);
        default: apply_config($urandom_range(0, 9) < 7, DIV_W'($urandom_range(0, 31)),
                              pick_gain(seg[0]), pick_gain(seg[0]), pick_gain(seg[0]),
                              pick_gain(seg[0]));
      endcase
      case (seg % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 81; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 81; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      for (int k = 0; k < SEG_ITEMS; k++) begin
        if (k % 48 == 0)
          sp_hold = SAMPLE_W'($urandom_range(0, 4095));
        spd_walk = sat12(int'(spd_walk) + int'($urandom_range(0, 32)) - 16);
        pick = $urandom_range(0, 99);
        if (pick < 70)
          send_sample(sat12(int'(last_duty) + int'($urandom_range(0, 64)) - 32),
                      spd_walk, sp_hold);
        else if (pick < 90)
          send_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        else
          send_sample(rail_sample(), rail_sample(), rail_sample());
      end
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  // Result side: random stalls and the field-by-field check
  always @(posedge clk) begin : result_check
    tick_result_t want;
    out_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_ticks.size() == 0) begin
        report_mismatch("result beat with nothing expected", int'(out_tdata), 0);
      end else begin
        want = expected_ticks.pop_front();
        if (out_tdata[SAMPLE_W-1:0] !== want.duty)
          report_mismatch("duty", int'(out_tdata[SAMPLE_W-1:0]), int'(want.duty));
        if (out_tdata[2*SAMPLE_W-1:SAMPLE_W] !== want.target)
          report_mismatch("current_target", int'(out_tdata[2*SAMPLE_W-1:SAMPLE_W]),
                          int'(want.target));
        if (out_tuser[0] !== want.updated)
          report_mismatch("outer_updated", int'(out_tuser[0]), int'(want.updated));
        if (out_tuser[1] !== want.clamped)
          report_mismatch("duty_clamped", int'(out_tuser[1]), int'(want.clamped));
        if (want.updated)
          n_updates++;
        if (want.clamped)
          n_clamped++;
      end
      n_results++;
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles", quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SPEED_MODE;
    cfg_wdata = '0;
    reset_controller();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_torque_mode();
    test_divider_limits();
    test_closed_loop();

    wait_idle();
    if (expected_ticks.size() != 0)
      report_mismatch("results never delivered", 0, expected_ticks.size());
    $display("covered %0d sample beats and %0d result beats over %0d register writes",
             n_items, n_results, n_writes);
    $display("speed loop updates %0d, duty on a rail %0d, mismatches %0d",
             n_updates, n_clamped, n_errors);
    if (n_errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
